/* design/gpt_pkg.sv */
// ----------------------------------------------------------------------------
// Grid placement table package
// Field widths, operation codes and undo entry kinds shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpt_pkg;

  localparam int KIND_W  = 3;
  localparam int ID_W    = 8;
  localparam int COORD_W = 7;
  localparam int GS_W    = 7;

  localparam logic [KIND_W-1:0] KIND_PLACE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNDO   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd5;

  typedef enum logic [1:0] {
    UNDO_NONE = 2'd0,
    UNDO_MOVE = 2'd1,
    UNDO_SWAP = 2'd2
  } undo_kind_t;

endpackage

`default_nettype wire

/* design/grid_placement_table_unit.sv */
// ----------------------------------------------------------------------------
// Grid placement table unit
// Occupancy grid of node ids plus per-node position table with one undo entry.
// ----------------------------------------------------------------------------
// Rejected or trivial items finish in idle; lookup reads the addressed cell;
// place, move and move undo check the target cell, then write it (ending at the
// check if taken); swap and swap undo write both cells; clear wipes the grid.
// Busy stays high until the result is issued; the cell RAM port sets the pace.
// After reset a clearing pass over every grid cell runs with busy high.
// Results are held one cycle under done; the receiver cannot stall them.
`default_nettype none

module grid_placement_table_unit #(
  parameter int GRID_MAX = 64,
  parameter int NODE_MAX = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [gpt_pkg::KIND_W-1:0]    kind,
  input  wire logic [gpt_pkg::ID_W-1:0]      node_a,
  input  wire logic [gpt_pkg::ID_W-1:0]      node_b,
  input  wire logic [gpt_pkg::COORD_W-1:0]   pos_x,
  input  wire logic [gpt_pkg::COORD_W-1:0]   pos_y,
  input  wire logic                          cfg_we,
  input  wire logic [gpt_pkg::GS_W-1:0]      cfg_data,
  output logic                               done,
  output logic                               ok,
  output logic                               occupied,
  output logic      [gpt_pkg::ID_W-1:0]      node_at
);

  import gpt_pkg::*;

  localparam int CW         = $clog2(GRID_MAX);
  localparam int AW         = 2 * CW;
  localparam int NODE_DEPTH = (NODE_MAX > 256) ? 256 : NODE_MAX;
  localparam int NW         = $clog2(NODE_DEPTH);
  localparam int SW         = 9;
  localparam int CELL_W     = ID_W + 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_WRITE   = 8'b0000_0100,
    S_SWAP_B  = 8'b0000_1000,
    S_SWAP_W1 = 8'b0001_0000,
    S_SWAP_W2 = 8'b0010_0000,
    S_LOOK    = 8'b0100_0000,
    S_CLEAR   = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [AW-1:0]         cnt;
  logic                  clr_report;
  logic [ID_W-1:0]       na;
  logic [ID_W-1:0]       nb;
  logic [CW-1:0]         tx;
  logic [CW-1:0]         ty;
  logic                  op_move;
  logic                  op_undo;
  logic [AW-1:0]         upos;
  logic [NODE_DEPTH-1:0] placed;
  undo_kind_t            undo_kind;
  logic [ID_W-1:0]       undo_a;
  logic [ID_W-1:0]       undo_b;
  logic [CW-1:0]         undo_x;
  logic [CW-1:0]         undo_y;
  logic [GS_W-1:0]       grid_size;

  logic [SW-1:0]         side;
  logic                  in_range;
  logic                  undo_range;
  logic                  node_ok_a;
  logic                  placed_a;
  logic                  placed_b;
  logic                  uplaced_a;
  logic                  uplaced_b;
  logic [CW-1:0]         tx_in;
  logic [CW-1:0]         ty_in;

  logic                  cell_we;
  logic [AW-1:0]         cell_waddr;
  logic [CELL_W-1:0]     cell_wdata;
  logic [AW-1:0]         cell_raddr;
  logic [CELL_W-1:0]     cell_rdata;
  logic                  pos_we;
  logic [NW-1:0]         pos_waddr;
  logic [AW-1:0]         pos_wdata;
  logic [NW-1:0]         pos_raddr;
  logic [AW-1:0]         pos_rdata;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (grid_size == '0) begin
      side = SW'(1);
    end else if (SW'(grid_size) > SW'(GRID_MAX)) begin
      side = SW'(GRID_MAX);
    end else begin
      side = SW'(grid_size);
    end
  end

  assign in_range   = !pos_x[COORD_W-1] && !pos_y[COORD_W-1]
                      && (SW'(pos_x[COORD_W-2:0]) < side)
                      && (SW'(pos_y[COORD_W-2:0]) < side);
  assign undo_range = (SW'(undo_x) < side) && (SW'(undo_y) < side);
  assign tx_in      = CW'(pos_x[COORD_W-2:0]);
  assign ty_in      = CW'(pos_y[COORD_W-2:0]);

  assign node_ok_a = (int'(node_a) < NODE_MAX);
  assign placed_a  = node_ok_a && placed[node_a[NW-1:0]];
  assign placed_b  = (int'(node_b) < NODE_MAX) && placed[node_b[NW-1:0]];
  assign uplaced_a = (int'(undo_a) < NODE_MAX) && placed[undo_a[NW-1:0]];
  assign uplaced_b = (int'(undo_b) < NODE_MAX) && placed[undo_b[NW-1:0]];

  always_comb begin
    cell_raddr = (kind == KIND_UNDO) ? {undo_x, undo_y} : {tx_in, ty_in};
    pos_raddr  = (kind == KIND_UNDO) ? undo_a[NW-1:0] : node_a[NW-1:0];
    cell_we    = 1'b0;
    cell_waddr = cnt;
    cell_wdata = '0;
    pos_we     = 1'b0;
    pos_waddr  = na[NW-1:0];
    pos_wdata  = {tx, ty};
    unique case (state)
      S_IDLE: begin
      end
      S_CHECK: begin
        cell_we    = !cell_rdata[CELL_W-1] && placed[na[NW-1:0]];
        cell_waddr = pos_rdata;
      end
      S_WRITE: begin
        cell_we    = 1'b1;
        cell_waddr = {tx, ty};
        cell_wdata = {1'b1, na};
        pos_we     = 1'b1;
      end
      S_SWAP_B: begin
        pos_raddr = nb[NW-1:0];
      end
      S_SWAP_W1: begin
        cell_we    = 1'b1;
        cell_waddr = pos_rdata;
        cell_wdata = {1'b1, na};
        pos_we     = 1'b1;
        pos_wdata  = pos_rdata;
      end
      S_SWAP_W2: begin
        cell_we    = 1'b1;
        cell_waddr = upos;
        cell_wdata = {1'b1, nb};
        pos_we     = 1'b1;
        pos_waddr  = nb[NW-1:0];
        pos_wdata  = upos;
      end
      S_LOOK: begin
      end
      S_CLEAR: begin
        cell_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  gpt_ram #(
    .WIDTH  (CELL_W),
    .ADDR_W (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  gpt_ram #(
    .WIDTH  (AW),
    .ADDR_W (NW)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      clr_report <= 1'b0;
      placed     <= '0;
      undo_kind  <= UNDO_NONE;
      grid_size  <= GS_W'(64);
      done       <= 1'b0;
      ok         <= 1'b0;
      occupied   <= 1'b0;
      node_at    <= '0;
    end else begin
      done     <= 1'b0;
      occupied <= 1'b0;
      node_at  <= '0;
      if (cfg_we) begin
        grid_size <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            done <= 1'b1;
            ok   <= 1'b0;
            case (kind)
              KIND_PLACE, KIND_MOVE: begin
                if (in_range && ((kind == KIND_PLACE) ? node_ok_a : placed_a)) begin
                  done    <= 1'b0;
                  na      <= node_a;
                  tx      <= tx_in;
                  ty      <= ty_in;
                  op_move <= (kind == KIND_MOVE);
                  op_undo <= 1'b0;
                  state   <= S_CHECK;
                end
              end
              KIND_SWAP: begin
                if (placed_a && placed_b) begin
                  done  <= 1'b0;
                  na    <= node_a;
                  nb    <= node_b;
                  state <= S_SWAP_B;
                end
              end
              KIND_UNDO: begin
                if (undo_kind != UNDO_NONE) begin
                  undo_kind <= UNDO_NONE;
                  ok        <= 1'b1;
                  if (undo_kind == UNDO_MOVE && uplaced_a && undo_range) begin
                    done    <= 1'b0;
                    na      <= undo_a;
                    tx      <= undo_x;
                    ty      <= undo_y;
                    op_move <= 1'b1;
                    op_undo <= 1'b1;
                    state   <= S_CHECK;
                  end else if (undo_kind == UNDO_SWAP && uplaced_a && uplaced_b) begin
                    done  <= 1'b0;
                    na    <= undo_a;
                    nb    <= undo_b;
                    state <= S_SWAP_B;
                  end
                end
              end
              KIND_CLEAR: begin
                done       <= 1'b0;
                placed     <= '0;
                undo_kind  <= UNDO_NONE;
                cnt        <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              KIND_LOOKUP: begin
                if (in_range) begin
                  done  <= 1'b0;
                  state <= S_LOOK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CHECK: begin
          if (cell_rdata[CELL_W-1]) begin
            done  <= 1'b1;
            ok    <= op_undo;
            state <= S_IDLE;
          end else begin
            if (op_move) begin
              undo_kind <= UNDO_MOVE;
              undo_a    <= na;
              undo_b    <= '0;
              undo_x    <= pos_rdata[AW-1:CW];
              undo_y    <= pos_rdata[CW-1:0];
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          placed[na[NW-1:0]] <= 1'b1;
          done               <= 1'b1;
          ok                 <= 1'b1;
          state              <= S_IDLE;
        end
        S_SWAP_B: begin
          upos  <= pos_rdata;
          state <= S_SWAP_W1;
        end
        S_SWAP_W1: begin
          undo_kind <= UNDO_SWAP;
          undo_a    <= na;
          undo_b    <= nb;
          undo_x    <= '0;
          undo_y    <= '0;
          state     <= S_SWAP_W2;
        end
        S_SWAP_W2: begin
          done  <= 1'b1;
          ok    <= 1'b1;
          state <= S_IDLE;
        end
        S_LOOK: begin
          done     <= 1'b1;
          ok       <= !cell_rdata[CELL_W-1];
          occupied <= cell_rdata[CELL_W-1];
          node_at  <= cell_rdata[CELL_W-1] ? cell_rdata[ID_W-1:0] : '0;
          state    <= S_IDLE;
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (&cnt) begin
            done       <= clr_report;
            ok         <= 1'b1;
            clr_report <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occupied_only_on_lookup: assert property (@(posedge clk) disable iff (rst)
    occupied |-> done && !ok)
    else $error("occupied raised without a failing result");

  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy) || $past(busy))
    else $error("result issued without a transfer in progress");

  a_write_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $past(state == S_CHECK))
    else $error("cell write entered without a free-cell check");

  a_swap_completes: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_W2) |=> (state == S_IDLE) && done && ok)
    else $error("swap did not complete with a result");

endmodule

`default_nettype wire

/* design/gpt_ram.sv */
// ----------------------------------------------------------------------------
// Grid placement table RAM
// Single write port, single read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gpt_ram #(
  parameter int WIDTH  = 9,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* dv/grid_placement_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// Grid placement table unit testbench
// Drives place, move, swap, undo, clear and lookup commands through the
// start/busy handshake and checks every done strobe against a cycle-free
// model of the grid, the node position table and the single undo entry.
// A directed part covers bounds, own-cell moves, self swaps, failed reverts
// and grid shrinking; random phases then run at several grid sizes and
// sender idle rates.
// ----------------------------------------------------------------------------
module grid_placement_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpt_pkg::*;

  localparam int GRID_CELLS = 64;
  localparam int NODE_COUNT = 256;
  localparam int POOL_N     = 10;

  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    node_a;
    logic [ID_W-1:0]    node_b;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } placement_cmd_t;

  typedef struct {
    logic            ok;
    logic            occupied;
    logic [ID_W-1:0] node_at;
  } placement_result_t;

  typedef struct {
    undo_kind_t      kind;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    int              x;
    int              y;
  } revert_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [KIND_W-1:0]  kind = '0;
  logic [ID_W-1:0]    node_a = '0;
  logic [ID_W-1:0]    node_b = '0;
  logic [COORD_W-1:0] pos_x = '0;
  logic [COORD_W-1:0] pos_y = '0;
  logic               cfg_we = 1'b0;
  logic [GS_W-1:0]    cfg_data = '0;
  logic               busy;
  logic               done;
  logic               ok;
  logic               occupied;
  logic [ID_W-1:0]    node_at;

  placement_result_t expected_results[$];
  placement_result_t head;

  bit              cell_taken [GRID_CELLS][GRID_CELLS];
  logic [ID_W-1:0] cell_owner [GRID_CELLS][GRID_CELLS];
  bit              node_placed [NODE_COUNT];
  int              node_col [NODE_COUNT];
  int              node_row [NODE_COUNT];
  revert_t         last_undo;
  int              grid_side;
  int              send_idle_pct;
  int              mismatch_count;
  logic [ID_W-1:0] node_pool [POOL_N];

  grid_placement_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .node_a   (node_a),
    .node_b   (node_b),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .ok       (ok),
    .occupied (occupied),
    .node_at  (node_at)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void wipe_grid();
    foreach (cell_taken[i, j]) begin
      cell_taken[i][j] = 1'b0;
      cell_owner[i][j] = '0;
    end
    foreach (node_placed[n]) begin
      node_placed[n] = 1'b0;
      node_col[n] = 0;
      node_row[n] = 0;
    end
    last_undo = '{UNDO_NONE, 8'd0, 8'd0, 0, 0};
  endfunction

  function automatic bit coord_ok(int x, int y);
    return x >= 0 && y >= 0 && x < grid_side && y < grid_side;
  endfunction

  function automatic void vacate_cell(int x, int y);
    cell_taken[x][y] = 1'b0;
    cell_owner[x][y] = '0;
  endfunction

  function automatic void seat_node(logic [ID_W-1:0] n, int x, int y);
    node_placed[n] = 1'b1;
    node_col[n] = x;
    node_row[n] = y;
    cell_taken[x][y] = 1'b1;
    cell_owner[x][y] = n;
  endfunction

  function automatic bit shift_node(logic [ID_W-1:0] n, int x, int y);
    int ox;
    int oy;
    if (!node_placed[n] || !coord_ok(x, y)) return 1'b0;
    if (cell_taken[x][y]) return 1'b0;
    ox = node_col[n];
    oy = node_row[n];
    last_undo = '{UNDO_MOVE, n, 8'd0, ox, oy};
    vacate_cell(ox, oy);
    seat_node(n, x, y);
    return 1'b1;
  endfunction

  function automatic bit exchange_nodes(logic [ID_W-1:0] u, logic [ID_W-1:0] v);
    int ux;
    int uy;
    int vx;
    int vy;
    if (!node_placed[u] || !node_placed[v]) return 1'b0;
    last_undo = '{UNDO_SWAP, u, v, 0, 0};
    ux = node_col[u];
    uy = node_row[u];
    vx = node_col[v];
    vy = node_row[v];
    seat_node(u, vx, vy);
    seat_node(v, ux, uy);
    return 1'b1;
  endfunction

  function automatic placement_result_t predict_placement(placement_cmd_t c);
    placement_result_t r;
    revert_t           e;
    int                x;
    int                y;
    r.ok = 1'b0;
    r.occupied = 1'b0;
    r.node_at = '0;
    x = int'($signed(c.pos_x));
    y = int'($signed(c.pos_y));
    case (c.kind)
      KIND_PLACE: begin
        if (coord_ok(x, y) && !cell_taken[x][y]) begin
          if (node_placed[c.node_a]) vacate_cell(node_col[c.node_a], node_row[c.node_a]);
          seat_node(c.node_a, x, y);
          r.ok = 1'b1;
        end
      end
      KIND_MOVE: r.ok = shift_node(c.node_a, x, y);
      KIND_SWAP: r.ok = exchange_nodes(c.node_a, c.node_b);
      KIND_UNDO: begin
        e = last_undo;
        if (e.kind != UNDO_NONE) begin
          last_undo.kind = UNDO_NONE;
          if (e.kind == UNDO_MOVE) void'(shift_node(e.a, e.x, e.y));
          else void'(exchange_nodes(e.a, e.b));
          r.ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        wipe_grid();
        r.ok = 1'b1;
      end
      KIND_LOOKUP: begin
        if (coord_ok(x, y)) begin
          if (cell_taken[x][y]) begin
            r.occupied = 1'b1;
            r.node_at = cell_owner[x][y];
          end else begin
            r.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatch_count++;
      end else begin
        head = expected_results.pop_front();
        if (ok !== head.ok) begin
          $error("ok: expected %0d, got %0d", head.ok, ok);
          mismatch_count++;
        end
        if (occupied !== head.occupied) begin
          $error("occupied: expected %0d, got %0d", head.occupied, occupied);
          mismatch_count++;
        end
        if (node_at !== head.node_at) begin
          $error("node_at: expected %0d, got %0d", head.node_at, node_at);
          mismatch_count++;
        end
      end
    end
  end

  task automatic issue_cmd(input logic [KIND_W-1:0] k, input int a, input int b,
                           input int x, input int y);
    placement_cmd_t c;
    c.kind = k;
    c.node_a = a[ID_W-1:0];
    c.node_b = b[ID_W-1:0];
    c.pos_x = x[COORD_W-1:0];
    c.pos_y = y[COORD_W-1:0];
    @(negedge clk);
    start <= 1'b1;
    kind <= c.kind;
    node_a <= c.node_a;
    node_b <= c.node_b;
    pos_x <= c.pos_x;
    pos_y <= c.pos_y;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_placement(c));
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_grid_size(input int v);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[GS_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    grid_side = int'(v[GS_W-1:0]);
    if (grid_side < 1) grid_side = 1;
    if (grid_side > GRID_CELLS) grid_side = GRID_CELLS;
  endtask

  function automatic logic [ID_W-1:0] pick_node();
    if ($urandom_range(99) < 85) return node_pool[$urandom_range(POOL_N - 1)];
    return ID_W'($urandom_range(255));
  endfunction

  function automatic void pick_cell(output int x, output int y);
    int              sel;
    logic [ID_W-1:0] n;
    sel = $urandom_range(9);
    x = $urandom_range(grid_side - 1);
    y = $urandom_range(grid_side - 1);
    if (sel >= 6 && sel < 8) begin
      n = node_pool[$urandom_range(POOL_N - 1)];
      if (node_placed[n]) begin
        x = node_col[n];
        y = node_row[n];
      end
    end else if (sel == 8) begin
      x = $urandom_range(63);
      y = $urandom_range(63);
    end else if (sel == 9) begin
      x = int'($signed(7'($urandom_range(127))));
      y = int'($signed(7'($urandom_range(127))));
    end
  endfunction

  task automatic test_place_lookup();
    issue_cmd(KIND_LOOKUP, 0, 0, 0, 0);
    issue_cmd(KIND_PLACE, 255, 0, 63, 63);
    issue_cmd(KIND_PLACE, 0, 0, 0, 0);
    issue_cmd(KIND_LOOKUP, 0, 0, 63, 63);
    issue_cmd(KIND_PLACE, 8'hAA, 0, -64, 5);
    issue_cmd(KIND_PLACE, 8'h55, 0, 0, 0);
    issue_cmd(KIND_RSVD7, 255, 255, -1, -1);
  endtask

  task automatic test_move_swap_undo();
    issue_cmd(KIND_MOVE, 8'h55, 0, 1, 1);
    issue_cmd(KIND_MOVE, 0, 0, 0, 0);
    issue_cmd(KIND_MOVE, 0, 0, 1, 2);
    issue_cmd(KIND_SWAP, 0, 255, 0, 0);
    issue_cmd(KIND_SWAP, 255, 255, 0, 0);
    issue_cmd(KIND_PLACE, 0, 0, 63, 62);
    issue_cmd(KIND_MOVE, 255, 0, 10, 10);
    issue_cmd(KIND_PLACE, 8'hAA, 0, 1, 2);
    issue_cmd(KIND_UNDO, 0, 0, 0, 0);
    issue_cmd(KIND_UNDO, 0, 0, 0, 0);
  endtask

  task automatic test_grid_size();
    write_grid_size(8);
    issue_cmd(KIND_PLACE, 8'h80, 0, 7, 7);
    issue_cmd(KIND_MOVE, 8'h80, 0, 2, 2);
    write_grid_size(3);
    issue_cmd(KIND_UNDO, 0, 0, 0, 0);
    issue_cmd(KIND_UNDO, 0, 0, 0, 0);
    issue_cmd(KIND_LOOKUP, 0, 0, 7, 7);
    write_grid_size(1);
    issue_cmd(KIND_LOOKUP, 0, 0, 0, 0);
    write_grid_size(64);
    issue_cmd(KIND_LOOKUP, 0, 0, 63, 62);
  endtask

  task automatic test_clear();
    issue_cmd(KIND_CLEAR, 0, 0, 0, 0);
    issue_cmd(KIND_LOOKUP, 0, 0, 63, 62);
    issue_cmd(KIND_MOVE, 0, 0, 1, 1);
  endtask

  task automatic test_random_traffic(input int count, input int side_cfg, input int idle_pct);
    int                pick;
    int                x;
    int                y;
    logic [ID_W-1:0]   a;
    logic [ID_W-1:0]   b;
    logic [KIND_W-1:0] k;
    write_grid_size(side_cfg);
    send_idle_pct = idle_pct;
    foreach (node_pool[i]) node_pool[i] = ID_W'($urandom_range(255));
    repeat (count) begin
      pick = $urandom_range(199);
      a = pick_node();
      b = pick_node();
      pick_cell(x, y);
      if (pick < 50) k = KIND_PLACE;
      else if (pick < 90) k = KIND_MOVE;
      else if (pick < 115) k = KIND_SWAP;
      else if (pick < 135) k = KIND_UNDO;
      else if (pick < 137) k = KIND_CLEAR;
      else if (pick < 139) k = KIND_RSVD6;
      else if (pick < 141) k = KIND_RSVD7;
      else k = KIND_LOOKUP;
      issue_cmd(k, a, b, x, y);
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  initial begin
    grid_side = GRID_CELLS;
    send_idle_pct = 0;
    mismatch_count = 0;
    wipe_grid();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_place_lookup();
    test_move_swap_undo();
    test_grid_size();
    test_clear();
    test_random_traffic(150, 6, 7);
    test_random_traffic(150, 127, 76);
    test_random_traffic(100, 4, 0);
    test_random_traffic(50, 0, 0);
    drain_results();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("grid_placement_table_unit_tb: done, clean");
    end else begin
      $display("grid_placement_table_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("grid_placement_table_unit_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
design/gpt_pkg.sv
design/gpt_ram.sv
design/grid_placement_table_unit.sv
dv/grid_placement_table_unit_tb.sv
